### design/tavcp_pkg.sv
`default_nettype none
package tavcp_pkg;

   // Longest line is LINE_CHARS-1 characters.
   localparam int LINE_CHARS = 32;
   localparam int COUNT_W    = $clog2(LINE_CHARS);

   localparam int ADDR_ACC_W  = 17;
   localparam int ADDR_WIDE_W = 22;
   localparam int VAL_ACC_W   = 32;
   localparam int VAL_WIDE_W  = 36;

   localparam logic [ADDR_ACC_W-1:0] ADDR_CAP = 17'h1_0000;
   localparam logic [VAL_ACC_W-1:0]  VAL_CAP  = 32'h8000_0000;
   localparam logic [VAL_ACC_W-1:0]  VAL_MAX_POS = 32'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   typedef enum logic [2:0] {
      PH_PRE_ADDR,
      PH_ADDR,
      PH_GAP,
      PH_VAL,
      PH_AFTER,
      PH_ENDED
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MISSING,
      ST_BAD_ADDR,
      ST_BAD_VALUE
   } status_type;

   typedef struct packed {
      logic [ADDR_ACC_W-1:0] accum;
      logic                  hex;
      logic                  neg;
      logic                  dig;
      logic                  bad;
      logic                  sign;
      logic                  lzero;
      logic [1:0]            pos;
   } addr_state_type;

   typedef struct packed {
      logic [VAL_ACC_W-1:0] accum;
      logic                 neg;
      logic                 dig;
      logic                 bad;
      logic                 sign;
   } val_state_type;

endpackage
`default_nettype wire

### design/tavcp_addr_step.sv
`default_nettype none
module tavcp_addr_step
   import tavcp_pkg::*;
(
   input  addr_state_type cur,
   input  logic [7:0]     ch,
   output addr_state_type nxt
);

   logic                   hex_ok;
   logic [3:0]             hex_d;
   logic [ADDR_WIDE_W-1:0] hex_sum;
   logic [ADDR_WIDE_W-1:0] dec_sum;
   logic [ADDR_WIDE_W-1:0] acc_wide;

   assign acc_wide = ADDR_WIDE_W'(cur.accum);

   always_comb begin
      hex_ok = 1'b1;
      hex_d  = '0;
      if (ch inside {[CH_ZERO:CH_NINE]}) begin
         hex_d = 4'(ch - CH_ZERO);
      end else if (ch inside {[CH_LOWER_A:CH_LOWER_F]}) begin
         hex_d = 4'(ch - CH_LOWER_A + 8'd10);
      end else if (ch inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         hex_d = 4'(ch - CH_UPPER_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hex_sum = (acc_wide << 4) + ADDR_WIDE_W'(hex_d);
   assign dec_sum = (acc_wide << 3) + (acc_wide << 1) + ADDR_WIDE_W'(hex_d);

   always_comb begin
      nxt = cur;
      if (cur.pos != 2'd2) begin
         nxt.pos = cur.pos + 2'd1;
      end
      if (!cur.bad) begin
         if (cur.pos == 2'd1 && cur.lzero && (ch == CH_LOWER_X || ch == CH_UPPER_X)) begin
            // switch to hex after a leading zero; digits restart
            nxt.hex   = 1'b1;
            nxt.dig   = 1'b0;
            nxt.accum = '0;
         end else if (cur.hex) begin
            if (hex_ok) begin
               nxt.accum = (hex_sum > ADDR_WIDE_W'(ADDR_CAP)) ? ADDR_CAP
                                                             : hex_sum[ADDR_ACC_W-1:0];
               nxt.dig   = 1'b1;
            end else begin
               nxt.bad = 1'b1;
            end
         end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            if (cur.pos == 2'd0 && ch == CH_ZERO) begin
               nxt.lzero = 1'b1;
            end
            nxt.accum = (dec_sum > ADDR_WIDE_W'(ADDR_CAP)) ? ADDR_CAP
                                                          : dec_sum[ADDR_ACC_W-1:0];
            nxt.dig   = 1'b1;
         end else if ((ch == CH_PLUS || ch == CH_MINUS) && !(cur.dig || cur.sign)) begin
            nxt.sign = 1'b1;
            if (ch == CH_MINUS) begin
               nxt.neg = 1'b1;
            end
         end else if ((ch == CH_VT || ch == CH_FF) && !(cur.dig || cur.sign)) begin
            // skip leading white space
            nxt.bad = 1'b0;
         end else begin
            nxt.bad = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### design/tavcp_val_step.sv
`default_nettype none
module tavcp_val_step
   import tavcp_pkg::*;
(
   input  val_state_type cur,
   input  logic [7:0]    ch,
   output val_state_type nxt
);

   logic [VAL_WIDE_W-1:0] acc_wide;
   logic [VAL_WIDE_W-1:0] dec_sum;

   assign acc_wide = VAL_WIDE_W'(cur.accum);
   assign dec_sum  = (acc_wide << 3) + (acc_wide << 1) + VAL_WIDE_W'(ch[3:0]);

   always_comb begin
      nxt = cur;
      if (!cur.bad) begin
         if (ch inside {[CH_ZERO:CH_NINE]}) begin
            nxt.accum = (dec_sum > VAL_WIDE_W'(VAL_CAP)) ? VAL_CAP
                                                        : dec_sum[VAL_ACC_W-1:0];
            nxt.dig   = 1'b1;
         end else if ((ch == CH_PLUS || ch == CH_MINUS) && !(cur.dig || cur.sign)) begin
            nxt.sign = 1'b1;
            if (ch == CH_MINUS) begin
               nxt.neg = 1'b1;
            end
         end else if ((ch == CH_VT || ch == CH_FF) && !(cur.dig || cur.sign)) begin
            // skip leading white space
            nxt.bad = 1'b0;
         end else begin
            nxt.bad = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### design/text_address_value_command_parser_core.sv
`default_nettype none
// Line parser for "address value" commands arriving one character per beat.
// Each req beat carries one received byte. Up to LINE_CHARS-1 characters form
// a line; one more character clears the line and is dropped. CR or LF closes
// a non-empty line and produces one rsp beat with the address (16 bits), the
// value (signed 32 bits, saturated) and a status: 0 ok, 1 missing token,
// 2 bad address, 3 bad value; address and value are zero unless status is 0.
// CR or LF on an empty line produces nothing. The address is hex after 0x/0X,
// else decimal with optional sign; a NUL ends the parsed text of a line.
// Rate: one character per clock cycle sustained. A character passes through
// an input register, is parsed by the incremental accumulators, and its
// result lands in the output register. The only stall is a full output
// register whose beat is not taken by rsp_tready.
module text_address_value_command_parser_core
   import tavcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] address, [47:16] value
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] ch_ff;

   // parser state
   logic [COUNT_W-1:0] count_ff, count_in;
   phase_type          phase_ff, phase_in;
   addr_state_type     addr_ff, addr_in;
   val_state_type      val_ff, val_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic           fire;
   logic           is_eol;
   logic           is_sep;
   logic           emit;
   phase_type      feed_phase;
   logic           feed_addr;
   logic           feed_val;
   addr_state_type addr_step;
   val_state_type  val_step;
   status_type     status;

   // process the held character when the result register can take a beat
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !fire);

   assign is_eol = (ch_ff == CH_LF) || (ch_ff == CH_CR);
   assign is_sep = (ch_ff == CH_SPACE) || (ch_ff == CH_TAB);

   tavcp_addr_step u_addr_step (
      .cur (addr_ff),
      .ch  (ch_ff),
      .nxt (addr_step)
   );

   tavcp_val_step u_val_step (
      .cur (val_ff),
      .ch  (ch_ff),
      .nxt (val_step)
   );

   // token phase next state for a character that is parsed
   always_comb begin
      feed_phase = phase_ff;
      case (phase_ff)
         PH_PRE_ADDR: begin
            if (ch_ff == CH_NUL)  feed_phase = PH_ENDED;
            else if (!is_sep)     feed_phase = PH_ADDR;
         end
         PH_ADDR: begin
            if (ch_ff == CH_NUL)  feed_phase = PH_ENDED;
            else if (is_sep)      feed_phase = PH_GAP;
         end
         PH_GAP: begin
            if (ch_ff == CH_NUL)  feed_phase = PH_ENDED;
            else if (!is_sep)     feed_phase = PH_VAL;
         end
         PH_VAL: begin
            if (ch_ff == CH_NUL || is_sep) feed_phase = PH_AFTER;
         end
         default: feed_phase = phase_ff;
      endcase
   end

   // which token accumulator takes the character
   always_comb begin
      feed_addr = 1'b0;
      feed_val  = 1'b0;
      case (phase_ff)
         PH_PRE_ADDR, PH_ADDR: feed_addr = (ch_ff != CH_NUL) && !is_sep;
         PH_GAP, PH_VAL:       feed_val  = (ch_ff != CH_NUL) && !is_sep;
         default: begin
            feed_addr = 1'b0;
            feed_val  = 1'b0;
         end
      endcase
   end

   // line status from the state left by the characters before CR/LF
   always_comb begin
      if (phase_ff != PH_VAL && phase_ff != PH_AFTER) begin
         status = ST_MISSING;
      end else if (addr_ff.bad || !addr_ff.dig || addr_ff.accum[16] ||
                   (addr_ff.neg && addr_ff.accum != '0)) begin
         status = ST_BAD_ADDR;
      end else if (val_ff.bad || !val_ff.dig) begin
         status = ST_BAD_VALUE;
      end else begin
         status = ST_OK;
      end
   end

   assign emit = fire && is_eol && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      addr_in  = addr_ff;
      val_in   = val_ff;
      if (fire) begin
         if (is_eol) begin
            if (count_ff != '0) begin
               count_in = '0;
               phase_in = PH_PRE_ADDR;
               addr_in  = '0;
               val_in   = '0;
            end
         end else if (count_ff < COUNT_W'(LINE_CHARS - 1)) begin
            count_in = count_ff + COUNT_W'(1);
            phase_in = feed_phase;
            if (feed_addr) addr_in = addr_step;
            if (feed_val)  val_in  = val_step;
         end else begin
            // line too long: drop the character and start over
            count_in = '0;
            phase_in = PH_PRE_ADDR;
            addr_in  = '0;
            val_in   = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_addr_in   = rsp_addr_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_status_in = status;
         rsp_addr_in   = '0;
         rsp_val_in    = '0;
         if (status == ST_OK) begin
            rsp_addr_in = addr_ff.accum[15:0];
            if (val_ff.neg) begin
               rsp_val_in = 32'(32'd0 - val_ff.accum);
            end else begin
               rsp_val_in = val_ff.accum[31] ? VAL_MAX_POS : val_ff.accum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= PH_PRE_ADDR;
         addr_ff      <= '0;
         val_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         val_ff       <= val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load a new character only when the slot frees up
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff <= req_tdata;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_val_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire
